/* rtl/spme_pkg.sv */
// Package: command, disposition and action codes, result record and helpers for the signal engine.
`default_nettype none

package spme_pkg;

	localparam int TASK_SLOTS_DEF = 64;
	localparam int SIGNAL_COUNT   = 32;
	localparam int SIG_W          = 5;
	localparam int MASK_W         = 32;
	localparam int ACT_W          = 2 * MASK_W;

	localparam logic [SIG_W-1:0] SIG_KILL = 5'd9;
	localparam logic [SIG_W-1:0] SIG_STOP = 5'd19;

	localparam logic [MASK_W-1:0] KILL_STOP_MASK = (32'd1 << SIG_KILL) | (32'd1 << SIG_STOP);
	localparam logic [MASK_W-1:0] DELIVER_MASK   = ~32'd1;

	localparam logic [2:0] CMD_INIT    = 3'd0;
	localparam logic [2:0] CMD_SEND    = 3'd1;
	localparam logic [2:0] CMD_MASK    = 3'd2;
	localparam logic [2:0] CMD_ACTION  = 3'd3;
	localparam logic [2:0] CMD_DELIVER = 3'd4;

	localparam logic [1:0] HOW_BLOCK   = 2'd0;
	localparam logic [1:0] HOW_UNBLOCK = 2'd1;
	localparam logic [1:0] HOW_SET     = 2'd2;
	localparam logic [1:0] HOW_BAD     = 2'd3;

	localparam logic [1:0] ACT_DEFAULT = 2'd0;
	localparam logic [1:0] ACT_IGNORE  = 2'd1;
	localparam logic [1:0] ACT_USER    = 2'd2;
	localparam logic [1:0] ACT_WIDE    = 2'd3;

	localparam logic [2:0] DISP_NONE    = 3'd0;
	localparam logic [2:0] DISP_IGNORED = 3'd1;
	localparam logic [2:0] DISP_CONT    = 3'd2;
	localparam logic [2:0] DISP_STOP    = 3'd3;
	localparam logic [2:0] DISP_TERM    = 3'd4;
	localparam logic [2:0] DISP_USER    = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic              status;
		logic [MASK_W-1:0] old_mask;
		logic [1:0]        old_action;
		logic [SIG_W-1:0]  delivered_signal;
		logic [2:0]        disposition;
		logic              wake_task;
		logic              last;
	} res_t;

	function automatic logic [2:0] default_disp(input logic [SIG_W-1:0] sig);
		logic [2:0] d;
		unique case (sig)
			5'd17, 5'd23, 5'd28:        d = DISP_IGNORED;
			5'd18:                      d = DISP_CONT;
			5'd19, 5'd20, 5'd21, 5'd22: d = DISP_STOP;
			default:                    d = DISP_TERM;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

/* rtl/signal_pending_mask_engine.sv */
// Top level: per-task signal state engine over synchronous pending, blocked and action memories.
`default_nettype none

// For every command the accept edge issues one read of the task's pending, blocked and action
// memories. Unless a deliver finds signals ready, the next edge modifies, writes back and
// registers the single result. A deliver with signals ready gives one result per cycle from a
// lowest-first search over the ready set that stops after a terminate; the pending word is
// written back with the last result. A deliver with nothing ready gives one result, DISP_NONE.
// Results appear on done for one cycle and cannot be held off. busy is high from the accept
// edge until the edge that registers the last result. Slot valid flags clear at reset.
module signal_pending_mask_engine
	import spme_pkg::*;
#(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  command,
	input  wire logic [5:0]  task_index,
	input  wire logic [5:0]  signal_number,
	input  wire logic [1:0]  mask_how,
	input  wire logic [31:0] mask_value,
	input  wire logic        mask_given,
	input  wire logic [1:0]  action_kind,
	input  wire logic        action_given,
	input  wire logic        task_sleeping,
	output logic             done,
	output logic             status,
	output logic [31:0]      old_mask,
	output logic [1:0]       old_action,
	output logic [4:0]       delivered_signal,
	output logic [2:0]       disposition,
	output logic             wake_task,
	output logic             last
);

	localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

	state_t state_q, state_d;

	logic [MASK_W-1:0] pend_mem [TASK_SLOTS];
	logic [MASK_W-1:0] blk_mem  [TASK_SLOTS];
	logic [ACT_W-1:0]  act_mem  [TASK_SLOTS];

	logic [TASK_SLOTS-1:0] valid_q;

	logic              accept;
	logic [AW-1:0]     rd_addr;
	logic              in_range;
	logic              acc_err;

	logic [AW-1:0]     addr_q;
	logic [2:0]        cmd_q;
	logic [5:0]        sig_q;
	logic [1:0]        how_q;
	logic [MASK_W-1:0] mval_q;
	logic              mgiven_q;
	logic [1:0]        kind_q;
	logic              agiven_q;
	logic              sleep_q;
	logic              err_q;

	logic [MASK_W-1:0] rd_pend_s1;
	logic [MASK_W-1:0] rd_blk_s1;
	logic [ACT_W-1:0]  rd_act_s1;

	logic [MASK_W-1:0] ready_q;
	logic [MASK_W-1:0] spend_q;
	logic [ACT_W-1:0]  sact_q;

	logic [MASK_W-1:0] exec_ready;
	logic              deliver_go;
	logic [SIG_W-1:0]  scan_idx;
	logic [MASK_W-1:0] scan_clr;
	logic [1:0]        scan_act;
	logic [2:0]        scan_disp;
	logic              scan_last;

	logic              pend_we, blk_we, act_we, valid_set, scan_load;
	logic [MASK_W-1:0] pend_wd, blk_wd, blk_new;
	logic [ACT_W-1:0]  act_wd;
	logic              done_d;
	res_t              res_d, res_q;
	logic              done_q;

	assign accept   = start && !busy;
	assign rd_addr  = AW'(task_index);
	assign in_range = 32'(task_index) < 32'(TASK_SLOTS);
	assign acc_err  = (command > CMD_DELIVER) || !in_range ||
		((command != CMD_INIT) && !valid_q[rd_addr]);
	assign busy     = (state_q != ST_IDLE);

	assign exec_ready = rd_pend_s1 & ~rd_blk_s1 & DELIVER_MASK;
	assign deliver_go = !err_q && (cmd_q == CMD_DELIVER) && (exec_ready != '0);

	always_comb begin
		scan_idx = '0;
		for (int i = SIGNAL_COUNT - 1; i >= 1; i--) begin
			if (ready_q[i]) begin
				scan_idx = SIG_W'(i);
			end
		end
	end

	assign scan_clr = MASK_W'(1) << scan_idx;
	assign scan_act = sact_q[{scan_idx, 1'b0} +: 2];

	always_comb begin
		if (scan_act == ACT_IGNORE) begin
			scan_disp = DISP_IGNORED;
		end else if (scan_act == ACT_DEFAULT) begin
			scan_disp = default_disp(scan_idx);
		end else begin
			scan_disp = DISP_USER;
		end
	end

	assign scan_last = (scan_disp == DISP_TERM) || ((ready_q & ~scan_clr) == '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = deliver_go ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		blk_new = rd_blk_s1;
		unique case (how_q)
			HOW_BLOCK:   blk_new = rd_blk_s1 | mval_q;
			HOW_UNBLOCK: blk_new = rd_blk_s1 & ~mval_q;
			HOW_SET:     blk_new = mval_q;
			HOW_BAD:     blk_new = rd_blk_s1;
		endcase
		if (!mgiven_q) begin
			blk_new = rd_blk_s1;
		end
	end

	always_comb begin
		res_d      = '0;
		res_d.last = 1'b1;
		done_d     = 1'b0;
		pend_we    = 1'b0;
		blk_we     = 1'b0;
		act_we     = 1'b0;
		valid_set  = 1'b0;
		scan_load  = 1'b0;
		pend_wd    = rd_pend_s1;
		blk_wd     = blk_new & ~KILL_STOP_MASK;
		act_wd     = rd_act_s1;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_EXEC: begin
				done_d = 1'b1;
				if (err_q) begin
					res_d.status = 1'b1;
				end else begin
					unique case (cmd_q)
						CMD_INIT: begin
							pend_we   = 1'b1;
							blk_we    = 1'b1;
							act_we    = 1'b1;
							valid_set = 1'b1;
							pend_wd   = '0;
							blk_wd    = '0;
							act_wd    = '0;
						end
						CMD_SEND: begin
							if (32'(sig_q) >= SIGNAL_COUNT) begin
								res_d.status = 1'b1;
							end else begin
								pend_we         = 1'b1;
								pend_wd         = rd_pend_s1 | (MASK_W'(1) << sig_q[SIG_W-1:0]);
								res_d.wake_task = sleep_q;
							end
						end
						CMD_MASK: begin
							blk_we         = 1'b1;
							res_d.old_mask = rd_blk_s1;
							res_d.status   = mgiven_q && (how_q == HOW_BAD);
						end
						CMD_ACTION: begin
							if ((sig_q == '0) || (32'(sig_q) >= SIGNAL_COUNT) ||
								(sig_q[SIG_W-1:0] == SIG_KILL) ||
								(sig_q[SIG_W-1:0] == SIG_STOP)) begin
								res_d.status = 1'b1;
							end else begin
								res_d.old_action = rd_act_s1[{sig_q[SIG_W-1:0], 1'b0} +: 2];
								act_we = agiven_q;
								act_wd[{sig_q[SIG_W-1:0], 1'b0} +: 2] =
									(kind_q == ACT_WIDE) ? ACT_USER : kind_q;
							end
						end
						CMD_DELIVER: begin
							if (exec_ready != '0) begin
								done_d    = 1'b0;
								scan_load = 1'b1;
							end else begin
								res_d.disposition = DISP_NONE;
							end
						end
						default: begin
							res_d.status = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				done_d                 = 1'b1;
				res_d.delivered_signal = scan_idx;
				res_d.disposition      = scan_disp;
				res_d.last             = scan_last;
				pend_wd                = spend_q & ~scan_clr;
				pend_we                = scan_last;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (valid_set) begin
				valid_q[addr_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q   <= rd_addr;
			cmd_q    <= command;
			sig_q    <= signal_number;
			how_q    <= mask_how;
			mval_q   <= mask_value;
			mgiven_q <= mask_given;
			kind_q   <= action_kind;
			agiven_q <= action_given;
			sleep_q  <= task_sleeping;
			err_q    <= acc_err;
		end
		if (scan_load) begin
			ready_q <= exec_ready;
			spend_q <= rd_pend_s1;
			sact_q  <= rd_act_s1;
		end else if (state_q == ST_SCAN) begin
			ready_q <= ready_q & ~scan_clr;
			spend_q <= spend_q & ~scan_clr;
		end
		res_q <= res_d;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_pend_s1 <= pend_mem[rd_addr];
			rd_blk_s1  <= blk_mem[rd_addr];
			rd_act_s1  <= act_mem[rd_addr];
		end
		if (pend_we) begin
			pend_mem[addr_q] <= pend_wd;
		end
		if (blk_we) begin
			blk_mem[addr_q] <= blk_wd;
		end
		if (act_we) begin
			act_mem[addr_q] <= act_wd;
		end
	end

	assign done             = done_q;
	assign status           = res_q.status;
	assign old_mask         = res_q.old_mask;
	assign old_action       = res_q.old_action;
	assign delivered_signal = res_q.delivered_signal;
	assign disposition      = res_q.disposition;
	assign wake_task        = res_q.wake_task;
	assign last             = res_q.last;

endmodule

`default_nettype wire

/* rtl/spme_checker.sv */
// Port-level checker for the signal engine and its bind to the top level.
`default_nettype none

module spme_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic        status,
	input wire logic        wake_task,
	input wire logic        last
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_burst_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done)
		else $error("deliver burst broke before its last result");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && last |=> !done)
		else $error("result followed a last result without a new transaction");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> last)
		else $error("error result not marked last");

	a_wake_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && wake_task |-> last && !status)
		else $error("wake on an error or multi-result transaction");

endmodule

bind signal_pending_mask_engine spme_checker u_spme_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.wake_task (wake_task),
	.last      (last)
);

`default_nettype wire
